FILE: rtl/core/rft_pkg.sv
package rft_pkg;

	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int RES_DEPTH = 2;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);

	localparam logic [7:0] CH_AT  = 8'h40;
	localparam logic [7:0] CH_SQ  = 8'h27;
	localparam logic [7:0] CH_DQ  = 8'h22;
	localparam logic [7:0] CH_BS  = 8'h5C;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;

	localparam logic [1:0] KIND_TEXT     = 2'd0;
	localparam logic [1:0] KIND_NAME     = 2'd1;
	localparam logic [1:0] KIND_NAME_END = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic       last;
	} out_t;

	typedef enum logic [2:0] {
		QM_UNQ = 3'b001,
		QM_SGL = 3'b010,
		QM_DBL = 3'b100
	} quote_t;

	typedef enum logic [2:0] {
		WM_BEFORE = 3'b001,
		WM_IN     = 3'b010,
		WM_AFTER  = 3'b100
	} word_t;

	typedef enum logic [1:0] {
		BODY_TEXT  = 2'd0,
		BODY_NAME  = 2'd1,
		BODY_END   = 2'd2,
		BODY_CLOSE = 2'd3
	} body_t;

	// one queued command: optional separator, optional opening quote, then the body
	typedef struct packed {
		logic       space;
		logic       open;
		body_t      body;
		logic [7:0] data;
	} cmd_t;

endpackage

FILE: rtl/core/rft_front.sv
module rft_front
	import rft_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  in_t  item,
	input  logic cmd_full,
	output logic cmd_push,
	output cmd_t cmd
);

	quote_t quote_q, quote_d;
	word_t  word_q, word_d;
	logic   esc_q, esc_d;
	logic   coll_q, coll_d;

	logic       accept;
	logic [7:0] c;
	logic       do_word;
	logic       do_close;
	logic       is_space;
	logic       q_unq, q_sgl, q_dbl;

	assign accept = push && !cmd_full;
	assign c      = item.data_byte;
	assign is_space = c inside {CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

	always_comb begin
		q_unq = 1'b0;
		q_sgl = 1'b0;
		q_dbl = 1'b0;
		case (quote_q)
			QM_SGL:  q_sgl = 1'b1;
			QM_DBL:  q_dbl = 1'b1;
			default: q_unq = 1'b1;
		endcase
	end

	// classify the byte
	always_comb begin
		quote_d  = quote_q;
		esc_d    = esc_q;
		do_word  = 1'b0;
		do_close = 1'b0;
		if (item.end_of_input) begin
			do_close = 1'b1;
			quote_d  = QM_UNQ;
			esc_d    = 1'b0;
		end else if (esc_q) begin
			esc_d   = 1'b0;
			do_word = 1'b1;
		end else if (c == CH_SQ) begin
			if (q_unq)
				quote_d = QM_SGL;
			else if (q_sgl)
				quote_d = QM_UNQ;
			else
				do_word = 1'b1;
		end else if (c == CH_DQ) begin
			if (q_unq)
				quote_d = QM_DBL;
			else if (q_dbl)
				quote_d = QM_UNQ;
			else
				do_word = 1'b1;
		end else if (c == CH_BS) begin
			esc_d = 1'b1;
		end else if (is_space) begin
			if (q_unq)
				do_close = 1'b1;
			else
				do_word = 1'b1;
		end else begin
			do_word = 1'b1;
		end
	end

	// turn the class into a command and the next word state
	always_comb begin
		word_d   = word_q;
		coll_d   = coll_q;
		cmd_push = 1'b0;
		cmd.space = 1'b0;
		cmd.open  = 1'b0;
		cmd.body  = BODY_TEXT;
		cmd.data  = c;
		if (do_word) begin
			if (coll_q) begin
				cmd_push = 1'b1;
				cmd.body = BODY_NAME;
			end else if (word_q != WM_IN && c == CH_AT) begin
				coll_d = 1'b1;
			end else begin
				cmd_push  = 1'b1;
				cmd.space = (word_q == WM_AFTER);
				cmd.open  = (word_q != WM_IN);
				word_d    = WM_IN;
			end
		end else if (do_close) begin
			if (coll_q) begin
				cmd_push = 1'b1;
				cmd.body = BODY_END;
				cmd.data = 8'h00;
				coll_d   = 1'b0;
			end else if (word_q == WM_IN) begin
				cmd_push = 1'b1;
				cmd.body = BODY_CLOSE;
				cmd.data = CH_SQ;
				word_d   = WM_AFTER;
			end
		end
		cmd_push = cmd_push && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q <= QM_UNQ;
			word_q  <= WM_BEFORE;
			esc_q   <= 1'b0;
			coll_q  <= 1'b0;
		end else if (accept) begin
			quote_q <= quote_d;
			word_q  <= word_d;
			esc_q   <= esc_d;
			coll_q  <= coll_d;
		end
	end

endmodule

FILE: rtl/core/rft_cmd_queue.sv
module rft_cmd_queue
	import rft_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	cmd_t                 mem_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMD_PTR_W:0]   count_q;

	assign full  = (count_q == (CMD_PTR_W+1)'(CMD_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/rft_back.sv
module rft_back
	import rft_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cmd_t head,
	input  logic cmd_empty,
	output logic cmd_pop,
	output out_t result,
	output logic empty,
	input  logic pop
);

	cmd_t       cur_q;
	logic       cur_valid_q;
	logic [1:0] exp_cnt_q;

	out_t       gen;
	logic       fire;
	logic       take;

	out_t                 res_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] res_wr_q, res_rd_q;
	logic [RES_PTR_W:0]   res_cnt_q;
	logic                 res_full;
	logic                 res_pop;

	assign res_full = (res_cnt_q == (RES_PTR_W+1)'(RES_DEPTH));
	assign empty    = (res_cnt_q == '0);
	assign result   = res_q[res_rd_q];
	assign res_pop  = pop && !empty;

	// next result word of the current command
	always_comb begin
		gen.out_byte = CH_SQ;
		gen.kind     = KIND_TEXT;
		gen.last     = 1'b0;
		if (cur_q.space) begin
			gen.out_byte = CH_SP;
		end else if (!cur_q.open) begin
			case (cur_q.body)
				BODY_TEXT: begin
					if (cur_q.data == CH_SQ) begin
						// embedded quote expands to ' \ ' '
						gen.out_byte = (exp_cnt_q == 2'd1) ? CH_BS : CH_SQ;
						gen.last     = (exp_cnt_q == 2'd3);
					end else begin
						gen.out_byte = cur_q.data;
						gen.last     = 1'b1;
					end
				end
				BODY_NAME: begin
					gen.out_byte = cur_q.data;
					gen.kind     = KIND_NAME;
					gen.last     = 1'b1;
				end
				BODY_END: begin
					gen.out_byte = 8'h00;
					gen.kind     = KIND_NAME_END;
					gen.last     = 1'b1;
				end
				default: begin
					gen.last = 1'b1;
				end
			endcase
		end
	end

	assign fire    = cur_valid_q && !res_full;
	assign take    = !cmd_empty && (!cur_valid_q || (fire && gen.last));
	assign cmd_pop = take;

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= head;
		end else if (fire) begin
			if (cur_q.space)
				cur_q.space <= 1'b0;
			else
				cur_q.open <= 1'b0;
		end
		if (fire)
			res_q[res_wr_q] <= gen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			exp_cnt_q   <= '0;
			res_wr_q    <= '0;
			res_rd_q    <= '0;
			res_cnt_q   <= '0;
		end else begin
			if (take)
				cur_valid_q <= 1'b1;
			else if (fire && gen.last)
				cur_valid_q <= 1'b0;
			if (take)
				exp_cnt_q <= '0;
			else if (fire && !cur_q.space && !cur_q.open)
				exp_cnt_q <= exp_cnt_q + 1'b1;
			if (fire)
				res_wr_q <= res_wr_q + 1'b1;
			if (res_pop)
				res_rd_q <= res_rd_q + 1'b1;
			case ({fire, res_pop})
				2'b10:   res_cnt_q <= res_cnt_q + 1'b1;
				2'b01:   res_cnt_q <= res_cnt_q - 1'b1;
				default: res_cnt_q <= res_cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/response_file_tokenizer_core.sv
// Response-file tokenizer. Bytes go in at up to one per cycle while full is
// low; each byte is classified at once and, if it causes any output, leaves
// one command in a four-deep queue. The back end expands each command into
// one to six result words, one per cycle while its two-word output queue has
// room, so the sustained rate is one result word per cycle, and the input sees
// full only when the command queue is full. A result reaches the ports through
// the command queue, the current-command register and the output queue. Words
// are single-quoted and space-separated, an embedded quote becomes four bytes,
// an '@' word streams its name as kind 1 bytes closed by a kind 2 marker, and
// last flags the final word caused by one input byte.
module response_file_tokenizer_core
	import rft_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  in_t  item,
	output logic full,
	output logic empty,
	input  logic pop,
	output out_t result
);

	logic cmd_push, cmd_full, cmd_pop, cmd_empty;
	cmd_t cmd, head;

	assign full = cmd_full;

	rft_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (cmd)
	);

	rft_cmd_queue u_cmd_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd),
		.full      (cmd_full),
		.pop       (cmd_pop),
		.head      (head),
		.empty     (cmd_empty)
	);

	rft_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command written into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command taken from an empty queue");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.kind == KIND_TEXT || result.kind == KIND_NAME ||
			result.kind == KIND_NAME_END))
		else $error("result kind out of range");

	a_end_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind == KIND_NAME_END) |-> (result.last && result.out_byte == 8'h00))
		else $error("include-name end marker malformed");

endmodule

FILE: bench/tb_response_file_tokenizer_core.sv
module tb_response_file_tokenizer_core;
	import rft_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_ITEMS = 30;

	typedef struct {
		in_t stim;
		int  typed;	// -1: predicted, else count of hand-written words
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	in_t  item = '0;
	logic full;
	logic empty;
	logic pop = 1'b0;
	out_t result;

	int send_idle = 0;
	int recv_stall = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	// tokenizer state as the bench sees it
	quote_t qmode;
	word_t  wmode;
	logic   esc;
	logic   naming;

	out_t step_words[$];
	out_t token_words[$];
	out_t typed_words[$];
	row_t rows[$];
	out_t due;

	response_file_tokenizer_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #5 clk = ~clk;

	task automatic emit(logic [7:0] b, logic [1:0] k);
		step_words.push_back('{out_byte: b, kind: k, last: 1'b0});
	endtask

	task automatic word_char(logic [7:0] c);
		if (naming) begin
			emit(c, KIND_NAME);
		end else if (wmode != WM_IN && c == CH_AT) begin
			naming = 1'b1;
		end else begin
			if (wmode == WM_AFTER)
				emit(CH_SP, KIND_TEXT);
			if (wmode != WM_IN) begin
				emit(CH_SQ, KIND_TEXT);
				wmode = WM_IN;
			end
			// embedded quote: close, escaped quote, reopen
			if (c == CH_SQ) begin
				emit(CH_SQ, KIND_TEXT);
				emit(CH_BS, KIND_TEXT);
				emit(CH_SQ, KIND_TEXT);
				emit(CH_SQ, KIND_TEXT);
			end else begin
				emit(c, KIND_TEXT);
			end
		end
	endtask

	task automatic close_word();
		if (naming) begin
			emit(8'h00, KIND_NAME_END);
			naming = 1'b0;
		end else if (wmode == WM_IN) begin
			emit(CH_SQ, KIND_TEXT);
			wmode = WM_AFTER;
		end
	endtask

	task automatic tokenize(in_t x);
		logic [7:0] c;
		c = x.data_byte;
		step_words = {};
		if (x.end_of_input) begin
			close_word();
			qmode = QM_UNQ;
			esc = 1'b0;
		end else if (esc) begin
			esc = 1'b0;
			word_char(c);
		end else if (c == CH_SQ) begin
			if (qmode == QM_UNQ)
				qmode = QM_SGL;
			else if (qmode == QM_SGL)
				qmode = QM_UNQ;
			else
				word_char(c);
		end else if (c == CH_DQ) begin
			if (qmode == QM_UNQ)
				qmode = QM_DBL;
			else if (qmode == QM_DBL)
				qmode = QM_UNQ;
			else
				word_char(c);
		end else if (c == CH_BS) begin
			esc = 1'b1;
		end else if (c inside {CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR}) begin
			if (qmode == QM_UNQ)
				close_word();
			else
				word_char(c);
		end else begin
			word_char(c);
		end
		if (step_words.size() != 0)
			step_words[step_words.size() - 1].last = 1'b1;
	endtask

	task automatic report(string what, out_t got, out_t want);
		$display("%0t mismatch %s: got byte %h kind %0d last %0b, want byte %h kind %0d last %0b",
			$time, what, got.out_byte, got.kind, got.last,
			want.out_byte, want.kind, want.last);
		mismatches++;
	endtask

	// hold push until the word is taken, idling beforehand at random
	task automatic send(in_t x);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= x;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic add(logic [7:0] b, logic eoi, int typed);
		rows.push_back('{stim: '{data_byte: b, end_of_input: eoi}, typed: typed});
	endtask

	task automatic tw(logic [7:0] b, logic [1:0] k, logic l);
		typed_words.push_back('{out_byte: b, kind: k, last: l});
	endtask

	function automatic in_t pick_item();
		in_t x;
		int r;
		r = $urandom_range(99);
		x.data_byte = 8'($urandom_range(255));
		x.end_of_input = 1'b0;
		if (r < 4) begin
			x.end_of_input = 1'b1;
		end else if (r < 40) begin
			x.data_byte = 8'($urandom_range(8'h7A, 8'h61));
		end else if (r < 52) begin
			case ($urandom_range(5))
				0: x.data_byte = CH_SP;
				1: x.data_byte = CH_TAB;
				2: x.data_byte = CH_LF;
				3: x.data_byte = CH_VT;
				4: x.data_byte = CH_FF;
				default: x.data_byte = CH_CR;
			endcase
		end else if (r < 60) begin
			x.data_byte = CH_SQ;
		end else if (r < 66) begin
			x.data_byte = CH_DQ;
		end else if (r < 71) begin
			x.data_byte = CH_BS;
		end else if (r < 76) begin
			x.data_byte = CH_AT;
		end
		return x;
	endfunction

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (token_words.size() == 0) begin
				report("no word due", result, '0);
			end else begin
				due = token_words.pop_front();
				if (result.out_byte !== due.out_byte)
					report("out_byte", result, due);
				if (result.kind !== due.kind)
					report("kind", result, due);
				if (result.last !== due.last)
					report("last", result, due);
			end
		end
		pop <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("[response_file_tokenizer_core] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		in_t x;
		qmode = QM_UNQ;
		wmode = WM_BEFORE;
		esc = 1'b0;
		naming = 1'b0;

		add(8'h61, 1'b0, 2);
		tw(CH_SQ, KIND_TEXT, 1'b0);
		tw(8'h61, KIND_TEXT, 1'b1);
		add(CH_AT, 1'b0, -1);
		add(CH_SP, 1'b0, 1);
		tw(CH_SQ, KIND_TEXT, 1'b1);
		add(CH_AT, 1'b0, 0);
		add(8'h00, 1'b0, 1);
		tw(8'h00, KIND_NAME, 1'b1);
		add(8'hFF, 1'b0, 1);
		tw(8'hFF, KIND_NAME, 1'b1);
		add(8'hFF, 1'b1, 1);
		tw(8'h00, KIND_NAME_END, 1'b1);
		// lone '@' gives only the end marker
		add(CH_AT, 1'b0, 0);
		add(8'h00, 1'b1, 1);
		tw(8'h00, KIND_NAME_END, 1'b1);
		add(CH_SQ, 1'b0, -1);
		add(8'h78, 1'b0, -1);
		add(CH_DQ, 1'b0, -1);
		add(CH_TAB, 1'b0, -1);
		add(CH_SQ, 1'b0, -1);
		add(CH_DQ, 1'b0, -1);
		add(CH_SQ, 1'b0, -1);
		add(CH_DQ, 1'b0, -1);
		add(CH_BS, 1'b0, -1);
		add(CH_BS, 1'b0, -1);
		add(CH_BS, 1'b0, -1);
		add(8'h00, 1'b1, -1);
		// escaped quote opening a new word: the six-word worst case
		add(CH_BS, 1'b0, -1);
		add(CH_SQ, 1'b0, 6);
		tw(CH_SP, KIND_TEXT, 1'b0);
		tw(CH_SQ, KIND_TEXT, 1'b0);
		tw(CH_SQ, KIND_TEXT, 1'b0);
		tw(CH_BS, KIND_TEXT, 1'b0);
		tw(CH_SQ, KIND_TEXT, 1'b0);
		tw(CH_SQ, KIND_TEXT, 1'b1);
		add(CH_VT, 1'b0, -1);
		add(CH_BS, 1'b0, -1);
		add(CH_AT, 1'b0, -1);
		add(CH_CR, 1'b0, -1);
		add(CH_SQ, 1'b0, -1);
		add(8'h00, 1'b1, -1);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 37;
		recv_stall = 78;
		foreach (rows[i]) begin
			send(rows[i].stim);
			tokenize(rows[i].stim);
			if (rows[i].typed < 0) begin
				foreach (step_words[j])
					token_words.push_back(step_words[j]);
			end else begin
				repeat (rows[i].typed)
					token_words.push_back(typed_words.pop_front());
			end
		end

		for (int phase = 0; phase < 3; phase++) begin
			// hold off until the block has drained
			push <= 1'b0;
			while (token_words.size() != 0)
				@(posedge clk);
			case (phase)
				0: begin
					send_idle = 37;
					recv_stall = 78;
				end
				1: begin
					send_idle = 78;
					recv_stall = 37;
				end
				default: begin
					send_idle = 0;
					recv_stall = 0;
				end
			endcase
			repeat (PHASE_ITEMS) begin
				x = pick_item();
				send(x);
				tokenize(x);
				foreach (step_words[j])
					token_words.push_back(step_words[j]);
			end
		end
		push <= 1'b0;

		while (token_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[response_file_tokenizer_core] OK");
		else
			$display("[response_file_tokenizer_core] ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/rft_pkg.sv
rtl/core/rft_front.sv
rtl/core/rft_cmd_queue.sv
rtl/core/rft_back.sv
rtl/core/response_file_tokenizer_core.sv
bench/tb_response_file_tokenizer_core.sv
